// ----- src/tedf_pkg.sv -----
// ----------------------------------------------------------------------------
// tedf_pkg: shared widths and constants of the thermocouple emulation DAC frame
// Field widths, the scaled polynomial coefficients, the DAC code divisor and
// the frame layout used by the front pipeline, the code queue and the byte
// serializer.
// ----------------------------------------------------------------------------
package tedf_pkg;

	localparam int TempW  = 16;
	localparam int OffW   = 17;
	localparam int CodeW  = 18;
	localparam int ByteW  = 8;
	localparam int FrameW = 24;
	localparam int IdxW   = 2;

	// Byte counter value of the third and final byte of a frame.
	localparam logic [IdxW-1:0] LastByteIdx = 2'd2;

	// Polynomial scaled by 1024e9 (one quarter of the 4096e9 scale):
	// M = ((24000 - t)*t + 2508800000)*t + 54886400000 - 1024000000*offset
	localparam longint CoefSquare = 64'sd24000;
	localparam longint CoefLinear = 64'sd2508800000;
	localparam longint CoefConst  = 64'sd54886400000;
	localparam longint CoefOffset = 64'sd1024000000;

	// code = floor(M / DivConst) for positive M.
	localparam longint DivConst = 64'sd19519531250;

	// The code estimate is ((M >> HiDrop) * RecipConst) >> 40 with
	// RecipConst = floor(2^56 / DivConst). It is never above the true
	// quotient and at most one below it.
	localparam longint RecipConst = 64'sd3691563;
	localparam int     RecipW     = 22;
	localparam int     HiDrop     = 16;
	localparam int     DivW       = 35;

	// A positive M stays below 2^47 and its code below 2^13 over the full
	// 16-bit temperature and 17-bit offset ranges.
	localparam int MagW = 47;
	localparam int QuoW = 13;

	// Widths of the pipeline terms, sized from the full 16-bit and 17-bit ranges.
	localparam int AW    = 17;
	localparam int P1W   = 32;
	localparam int BW    = 33;
	localparam int P2W   = 48;
	localparam int OtW   = 47;
	localparam int MW    = 49;

	localparam int QueueDepthDef = 4;

endpackage

// ----- src/thermocouple_emulation_dac_frame.sv -----
// ----------------------------------------------------------------------------
// thermocouple_emulation_dac_frame: thermocouple emulator DAC frame generator
// Converts a temperature to the DAC code of the thermocouple voltage and
// sends the 24-bit DAC frame as three bytes.
// ----------------------------------------------------------------------------
// Each temperature item (1/16 degree Celsius) yields three frame bytes, most
// significant first, with last_byte set on the third. The byte serializer
// sends one byte per cycle while the output does not stall and takes no new
// code until the last byte of the current one is taken; the next code loads
// in the cycle its last byte is taken. The input is accepted on every cycle
// that the 6-stage polynomial and division pipeline can advance; each item
// passes the pipeline, a queue of QueueDepth codes and the serializer before
// its first byte appears. The offset register may only be written while no
// item is in flight.
module thermocouple_emulation_dac_frame import tedf_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic signed [OffW-1:0]  cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [TempW-1:0] temperature,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ByteW-1:0]        frame_byte,
	output logic                    last_byte
);

	logic signed [OffW-1:0] offset_q;

	logic             fr_valid, fr_stall;
	logic [CodeW-1:0] fr_code;
	logic             bk_valid, bk_stall;
	logic [CodeW-1:0] bk_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	tedf_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.offset_microvolts (offset_q),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.temperature       (temperature),
		.out_valid         (fr_valid),
		.out_stall         (fr_stall),
		.out_code          (fr_code)
	);

	tedf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_stall  (fr_stall),
		.in_code   (fr_code),
		.out_valid (bk_valid),
		.out_stall (bk_stall),
		.out_code  (bk_code)
	);

	tedf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (bk_valid),
		.in_stall   (bk_stall),
		.in_code    (bk_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

// ----- src/tedf_front.sv -----
// ----------------------------------------------------------------------------
// tedf_front: polynomial and DAC code pipeline
// Three stages evaluate the scaled cubic in Horner form. A fourth stage
// estimates the code by multiplying the upper bits of the value with a scaled
// reciprocal of the full-scale constant, a fifth multiplies the estimate back,
// and a sixth adds one where the remainder still holds a whole divisor. The
// whole pipeline holds when its last stage has a code that the queue cannot
// take.
// ----------------------------------------------------------------------------
module tedf_front import tedf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [OffW-1:0]  offset_microvolts,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [TempW-1:0] temperature,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CodeW-1:0]        out_code
);

	localparam int HiW    = MagW - HiDrop;
	localparam int QProdW = HiW + RecipW;
	localparam int QdW    = QuoW + DivW;
	localparam logic [RecipW-1:0] Recip   = RecipW'(RecipConst);
	localparam logic [DivW-1:0]   DivBase = DivW'(DivConst);

	logic adv;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [TempW-1:0] t_s1;
	logic signed [P1W-1:0]   p1_s1;
	logic signed [OtW-1:0]   ot_s1, ot_s2;
	logic signed [P2W-1:0]   p2_s2;
	logic signed [MW-1:0]    m_s3;
	logic [MagW-1:0]         mag_s4, mag_s5;
	logic [QuoW-1:0]         quo_s4, quo_s5;
	logic [MagW-1:0]         qd_s5;
	logic [CodeW-1:0]        code_s6;

	logic signed [AW-1:0]    a_c;
	logic signed [BW-1:0]    prod1_c;
	logic signed [BW-1:0]    b_c;
	logic signed [P2W-1:0]   prod2_c;
	logic signed [OtW-1:0]   ot_c;
	logic signed [MW-1:0]    m_c;
	logic [MagW-1:0]         mag_c;
	logic [QProdW-1:0]       qprod_c;
	logic [QdW-1:0]          qd_c;
	logic [MagW-1:0]         rem_c;

	assign adv       = !(vld_s6 && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_s6;
	assign out_code  = code_s6;

	always_comb begin
		a_c     = AW'(CoefSquare) - AW'(temperature);
		prod1_c = BW'(a_c) * BW'(temperature);
		ot_c    = OtW'(offset_microvolts) * OtW'(CoefOffset);
		b_c     = BW'(p1_s1) + BW'(CoefLinear);
		prod2_c = P2W'(b_c) * P2W'(t_s1);
		m_c     = MW'(p2_s2) + MW'(CoefConst) - MW'(ot_s2);
	end

	// A negative or zero voltage gives code zero, so the division only sees
	// positive values. The polynomial over its whole input range stays far
	// below full scale, so the quotient always fits the code width.
	always_comb begin
		mag_c   = (m_s3 > MW'(0)) ? MagW'($unsigned(m_s3)) : '0;
		qprod_c = QProdW'(mag_c[MagW-1:HiDrop]) * QProdW'(Recip);
		qd_c    = QdW'(quo_s4) * QdW'(DivBase);
		rem_c   = mag_s5 - qd_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= temperature;
			p1_s1   <= prod1_c[P1W-1:0];
			ot_s1   <= ot_c;
			p2_s2   <= prod2_c;
			ot_s2   <= ot_s1;
			m_s3    <= m_c;
			mag_s4  <= mag_c;
			quo_s4  <= qprod_c[QProdW-1 -: QuoW];
			mag_s5  <= mag_s4;
			quo_s5  <= quo_s4;
			qd_s5   <= qd_c[MagW-1:0];
			code_s6 <= (rem_c >= MagW'(DivBase)) ? CodeW'(quo_s5) + CodeW'(1)
				: CodeW'(quo_s5);
		end
	end

endmodule

// ----- src/tedf_queue.sv -----
// ----------------------------------------------------------------------------
// tedf_queue: code queue between the pipeline and the serializer
// A small FIFO of DAC codes that lets the front and the back stall on their
// own. Depth must be at least two.
// ----------------------------------------------------------------------------
module tedf_queue import tedf_pkg::*; #(
	parameter int Depth = QueueDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CodeW-1:0] in_code,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CodeW-1:0] out_code
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	logic [CodeW-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             push, pop;

	assign in_stall  = (cnt_q == CntW'(Depth));
	assign out_valid = (cnt_q != '0);
	assign out_code  = mem_q[rd_ptr_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/tedf_back.sv -----
// ----------------------------------------------------------------------------
// tedf_back: frame byte serializer
// Loads a DAC code as the 24-bit frame code<<2 and sends its three bytes,
// most significant first, flagging the third. The next code loads in the
// cycle that the last byte is taken.
// ----------------------------------------------------------------------------
module tedf_back import tedf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CodeW-1:0] in_code,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ByteW-1:0] frame_byte,
	output logic             last_byte
);

	logic              busy_q;
	logic [IdxW-1:0]   idx_q;
	logic [FrameW-1:0] frame_q;
	logic              taken, load;

	assign out_valid  = busy_q;
	assign last_byte  = (idx_q == LastByteIdx);
	assign frame_byte = frame_q[FrameW-1 -: ByteW];
	assign taken      = busy_q && !out_stall;
	assign in_stall   = busy_q && !(taken && last_byte);
	assign load       = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (taken) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= FrameW'({in_code, 2'b00});
		end else if (taken) begin
			frame_q <= frame_q << ByteW;
		end
	end

endmodule

// ----- sim/thermocouple_emulation_dac_frame_checker.sv -----
// ----------------------------------------------------------------------------
// thermocouple_emulation_dac_frame_checker: frame byte predictor and scoreboard
// Watches the offset register port and both item channels of the DAC frame
// generator. Every accepted temperature is turned into its three expected frame
// bytes, which are compared in order with the bytes that leave the block.
// ----------------------------------------------------------------------------
module thermocouple_emulation_dac_frame_checker import tedf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic signed [OffW-1:0]  cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [TempW-1:0] temperature,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [ByteW-1:0]        frame_byte,
	input  logic                    last_byte,
	output int                      fail_count,
	output int                      bytes_pending,
	output int                      temps_taken,
	output int                      zero_codes
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CodeTop = (64'sd1 << CodeW) - 1;

	typedef struct packed {
		logic [ByteW-1:0] value;
		logic             last;
	} frame_byte_t;

	frame_byte_t                bytes_due[$];
	logic signed [OffW-1:0]     offset_uv;

	// The polynomial is kept exact on a scale of 4096e9 per millivolt, so the
	// division below truncates toward zero just as the DAC code is defined.
	function automatic logic [CodeW-1:0] dac_code_for(input logic signed [TempW-1:0] t_in,
			input logic signed [OffW-1:0] off_in);
		longint t;
		longint off;
		longint scaled;
		longint code;
		t = longint'(t_in);
		off = longint'(off_in);
		scaled = -64'sd4 * t * t * t + 64'sd96000 * t * t + 64'sd10035200000 * t
			+ 64'sd219545600000 - 64'sd4096000000 * off;
		code = (scaled * 64'sd64) / 64'sd4997000000000;
		if (code < 0)
			code = 0;
		if (code > CodeTop)
			code = CodeTop;
		return code[CodeW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [CodeW-1:0]   code;
		logic [FrameW-1:0]  frame;
		frame_byte_t        due;
		if (!arst_n) begin
			offset_uv <= '0;
			bytes_due.delete();
			fail_count = 0;
			bytes_pending = 0;
			temps_taken = 0;
			zero_codes = 0;
		end else begin
			if (cfg_we)
				offset_uv <= cfg_wdata;
			if (in_valid && !in_stall) begin
				code = dac_code_for(temperature, offset_uv);
				frame = FrameW'({code, 2'b00});
				if (code == '0)
					zero_codes++;
				temps_taken++;
				for (int k = 0; k < 3; k++) begin
					due.value = frame[FrameW-1-8*k -: ByteW];
					due.last = (k == 2);
					bytes_due.push_back(due);
				end
			end
			if (out_valid && !out_stall) begin
				if (bytes_due.size() == 0) begin
					fail_count++;
					$display("%0t: frame byte %02h last %b arrived with none expected",
						$time, frame_byte, last_byte);
				end else begin
					due = bytes_due.pop_front();
					if (frame_byte !== due.value) begin
						fail_count++;
						$display("%0t: frame_byte expected %02h actual %02h",
							$time, due.value, frame_byte);
					end
					if (last_byte !== due.last) begin
						fail_count++;
						$display("%0t: last_byte expected %b actual %b",
							$time, due.last, last_byte);
					end
				end
			end
			bytes_pending = bytes_due.size();
		end
	end

endmodule

// ----- sim/thermocouple_emulation_dac_frame_tb.sv -----
// ----------------------------------------------------------------------------
// thermocouple_emulation_dac_frame_tb: testbench of the DAC frame generator
// Sends directed temperatures at the field and working-range extremes under
// extreme offsets, then phases of random temperatures, each phase under its own
// offset, with random gaps and output stalls except in every third phase. The
// checker beside the block predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module thermocouple_emulation_dac_frame_tb import tedf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 200000;
	localparam int Phases = 8;
	localparam int PhaseItems = 26;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic signed [OffW-1:0]  cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [TempW-1:0] temperature;
	logic                    out_valid;
	logic                    out_stall;
	logic [ByteW-1:0]        frame_byte;
	logic                    last_byte;

	int fail_count;
	int bytes_pending;
	int temps_taken;
	int zero_codes;
	int cycles;
	int offset_low;
	int offset_high;
	bit gaps_on;

	thermocouple_emulation_dac_frame dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

	thermocouple_emulation_dac_frame_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.temperature   (temperature),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.last_byte     (last_byte),
		.fail_count    (fail_count),
		.bytes_pending (bytes_pending),
		.temps_taken   (temps_taken),
		.zero_codes    (zero_codes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Output side: stall a random number of cycles, then take one byte.
	initial begin
		int unsigned hold;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = gaps_on ? $urandom_range(0, 8) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	task automatic send_temperature(input logic signed [TempW-1:0] t);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		temperature <= t;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stops sending and waits until every frame byte has come out.
	task automatic wait_frames_out();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (bytes_pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_offset(input logic signed [OffW-1:0] uv);
		wait_frames_out();
		cfg_we <= 1'b1;
		cfg_wdata <= uv;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (int'(uv) < offset_low)
			offset_low = int'(uv);
		if (int'(uv) > offset_high)
			offset_high = int'(uv);
	endtask

	// Mostly the working range, some full-width values and some near zero.
	function automatic logic signed [TempW-1:0] pick_temperature();
		int unsigned kind;
		int v;
		kind = $urandom_range(0, 9);
		if (kind < 8)
			v = int'($urandom_range(0, 26272)) - 4320;
		else if (kind == 8)
			v = int'($urandom());
		else
			v = int'($urandom_range(0, 400)) - 200;
		return v[TempW-1:0];
	endfunction

	initial begin
		logic signed [OffW-1:0] uv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		temperature = '0;
		out_stall = 1'b0;
		gaps_on = 1'b1;
		offset_low = 0;
		offset_high = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Offset left at its reset value: range ends, field ends, sign edges.
		send_temperature(-16'sd4320);
		send_temperature(16'sd21952);
		send_temperature(-16'sd32768);
		send_temperature(16'sd32767);
		send_temperature(16'sd0);
		send_temperature(-16'sd1);
		send_temperature(16'sd1);
		send_temperature(16'sh5555);
		send_temperature(-16'sh5556);
		send_temperature(16'sd16000);
		// Most negative offset gives the largest voltage the fields allow.
		set_offset(-17'sd65536);
		send_temperature(16'sd32767);
		send_temperature(16'sd21952);
		send_temperature(-16'sd32768);
		// Most positive offset pushes the voltage below zero for all but the top temperature.
		set_offset(17'sd65535);
		send_temperature(-16'sd4320);
		send_temperature(16'sd32767);
		send_temperature(16'sd8000);
		set_offset(-17'sd50000);
		send_temperature(16'sd21952);
		send_temperature(-16'sd4320);
		set_offset(17'sd50000);
		send_temperature(16'sd21952);
		send_temperature(16'sd0);

		for (int p = 0; p < Phases; p++) begin
			if (p % 4 == 3)
				uv = OffW'($urandom());
			else
				uv = OffW'(int'($urandom_range(0, 100000)) - 50000);
			set_offset(uv);
			gaps_on = (p % 3 != 2);
			for (int i = 0; i < PhaseItems; i++)
				send_temperature(pick_temperature());
		end

		wait_frames_out();
		repeat (40) @(negedge clk);
		$display("covered %0d temperatures, %0d of them clamped to code zero,",
			temps_taken, zero_codes);
		$display("under offsets from %0d to %0d microvolts", offset_low, offset_high);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
